// ===== hw/rtl/sfr_pkg.sv =====
// Shared types and constants for the framed serial receiver with CRC-16 check.
`timescale 1ns / 1ps
package sfr_pkg;

    localparam int unsigned LEN_W = 13;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd256;

    localparam logic [7:0] HDR_BYTE_0 = 8'hDD;
    localparam logic [7:0] HDR_BYTE_1 = 8'hCC;
    localparam logic [7:0] HDR_BYTE_2 = 8'hBB;
    localparam logic [7:0] HDR_BYTE_3 = 8'hAA;

    localparam logic [7:0] FTR_BYTE_0 = 8'hAA;
    localparam logic [7:0] FTR_BYTE_1 = 8'hBB;
    localparam logic [7:0] FTR_BYTE_2 = 8'hCC;
    localparam logic [7:0] FTR_BYTE_3 = 8'hDD;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] STATUS_GOOD       = 2'd0;
    localparam logic [1:0] STATUS_BAD_FOOTER = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC    = 2'd2;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [1:0] frame_status;
    } t_result;

endpackage

// ===== hw/rtl/sfr_if.sv =====
// Valid/ready channel interfaces for received bytes, results and configuration.
`timescale 1ns / 1ps
interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;

    modport source (output valid, output result_kind, output payload_byte,
                    output frame_status, input ready);
    modport sink (input valid, input result_kind, input payload_byte,
                  input frame_status, output ready);
endinterface

interface sfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] payload_length;

    modport source (output valid, output payload_length, input ready);
    modport sink (input valid, input payload_length, output ready);
endinterface

// ===== hw/rtl/sfr_ctrl.sv =====
// Frame state machine: header hunt, payload pass-through with CRC, CRC and footer check.
`timescale 1ns / 1ps
module sfr_ctrl
    import sfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_write,
    input  logic [LEN_W-1:0] i_cfg_length,
    input  logic             i_byte_valid,
    input  logic [7:0]       i_byte,
    output logic             o_push,
    output t_result          o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int unsigned EFF_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [EFF_W-1:0] MAX_LEN = EFF_W'(MAX_PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_PAYLOAD,
        PH_CRC,
        PH_FOOTER
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [23:0]      r_window, n_window;
    logic [CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [1:0]       r_sub_cnt, n_sub_cnt;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_rx_crc, n_rx_crc;
    logic             r_footer_good, n_footer_good;
    logic [LEN_W-1:0] r_length;

    logic [EFF_W-1:0] eff_length;
    logic [EFF_W-1:0] cnt_inc;
    logic [7:0]       footer_expected;
    logic             footer_ok;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    always_comb begin
        if (r_length == '0) begin
            eff_length = EFF_W'(1);
        end else if (EFF_W'(r_length) > MAX_LEN) begin
            eff_length = MAX_LEN;
        end else begin
            eff_length = EFF_W'(r_length);
        end
    end

    assign cnt_inc = EFF_W'(r_byte_cnt) + EFF_W'(1);

    always_comb begin
        case (r_sub_cnt)
            2'd0: footer_expected = FTR_BYTE_0;
            2'd1: footer_expected = FTR_BYTE_1;
            2'd2: footer_expected = FTR_BYTE_2;
            default: footer_expected = FTR_BYTE_3;
        endcase
    end

    assign footer_ok = r_footer_good && (i_byte == footer_expected);

    always_comb begin
        n_phase       = r_phase;
        n_window      = r_window;
        n_byte_cnt    = r_byte_cnt;
        n_sub_cnt     = r_sub_cnt;
        n_crc         = r_crc;
        n_rx_crc      = r_rx_crc;
        n_footer_good = r_footer_good;
        o_push        = 1'b0;
        o_result      = '0;

        if (i_byte_valid) begin
            case (r_phase)
                PH_HUNT: begin
                    if (r_window == {HDR_BYTE_0, HDR_BYTE_1, HDR_BYTE_2}
                        && i_byte == HDR_BYTE_3) begin
                        n_phase       = PH_PAYLOAD;
                        n_byte_cnt    = '0;
                        n_sub_cnt     = '0;
                        n_crc         = CRC_INIT;
                        n_rx_crc      = '0;
                        n_footer_good = 1'b1;
                        n_window      = '0;
                    end else begin
                        n_window = {r_window[15:0], i_byte};
                    end
                end
                PH_PAYLOAD: begin
                    n_crc = crc_byte(r_crc, i_byte);
                    if (cnt_inc >= eff_length) begin
                        n_phase    = PH_CRC;
                        n_byte_cnt = '0;
                        n_sub_cnt  = '0;
                    end else begin
                        n_byte_cnt = cnt_inc[CNT_W-1:0];
                    end
                    o_push                = 1'b1;
                    o_result.result_kind  = KIND_PAYLOAD;
                    o_result.payload_byte = i_byte;
                    o_result.frame_status = STATUS_GOOD;
                end
                PH_CRC: begin
                    if (r_sub_cnt == 2'd0) begin
                        n_rx_crc  = {8'h00, i_byte};
                        n_sub_cnt = 2'd1;
                    end else begin
                        n_rx_crc  = {i_byte, r_rx_crc[7:0]};
                        n_phase   = PH_FOOTER;
                        n_sub_cnt = 2'd0;
                    end
                end
                PH_FOOTER: begin
                    n_footer_good = footer_ok;
                    if (r_sub_cnt != 2'd3) begin
                        n_sub_cnt = r_sub_cnt + 2'd1;
                    end else begin
                        o_push                = 1'b1;
                        o_result.result_kind  = KIND_STATUS;
                        o_result.payload_byte = 8'h00;
                        if (!footer_ok) begin
                            o_result.frame_status = STATUS_BAD_FOOTER;
                        end else if (r_rx_crc != r_crc) begin
                            o_result.frame_status = STATUS_BAD_CRC;
                        end else begin
                            o_result.frame_status = STATUS_GOOD;
                        end
                        n_phase       = PH_HUNT;
                        n_window      = '0;
                        n_byte_cnt    = '0;
                        n_sub_cnt     = '0;
                        n_footer_good = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_window      <= '0;
            r_byte_cnt    <= '0;
            r_sub_cnt     <= '0;
            r_crc         <= CRC_INIT;
            r_rx_crc      <= '0;
            r_footer_good <= 1'b1;
            r_length      <= LEN_RESET;
        end else begin
            r_phase       <= n_phase;
            r_window      <= n_window;
            r_byte_cnt    <= n_byte_cnt;
            r_sub_cnt     <= n_sub_cnt;
            r_crc         <= n_crc;
            r_rx_crc      <= n_rx_crc;
            r_footer_good <= n_footer_good;
            if (i_cfg_write) begin
                r_length <= i_cfg_length;
            end
        end
    end

endmodule

// ===== hw/rtl/sfr_out_buf.sv =====
// Two-entry result buffer that decouples the frame logic from the result consumer.
`timescale 1ns / 1ps
module sfr_out_buf
    import sfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;
    logic       push;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;
    assign push     = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10: r_count <= r_count + 2'd1;
                2'b01: r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/serial_frame_receiver_crc16_core.sv =====
// Top level of the framed serial receiver with CRC-16/XMODEM check.
//
// The block takes one received byte per request on i_byte and hunts for the
// header DD CC BB AA. After it, payload_length payload bytes (0 acts as 1) are
// passed on at once as payload results, up to MAX_PAYLOAD_BYTES; two CRC bytes
// (low byte first) and the footer AA BB CC DD follow, and the last footer byte
// yields one status result. A bad footer is reported ahead of a CRC mismatch.
// The frame logic handles a byte in the cycle of its request, and the result
// is registered before o_result shows it, so a byte can be taken every cycle
// while the buffer has room. A two-entry result buffer lets a new byte be
// accepted while an earlier result still waits. When the result consumer
// stalls, the buffer fills and i_byte.ready drops until an entry is taken.
// The single register payload_length is written through i_cfg, which is
// always ready; write it only while no frame is in progress.
// Reset returns the block to hunting, empties the result buffer and sets the
// payload length to 256 bytes.
`timescale 1ns / 1ps
module serial_frame_receiver_crc16_core
    import sfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD_BYTES = 4096
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sfr_cfg_if.sink      i_cfg,
    sfr_byte_if.sink     i_byte,
    sfr_result_if.source o_result
);

    logic    full;
    logic    accept;
    logic    push;
    t_result ctrl_result;
    t_result buf_result;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = !full;
    assign accept       = i_byte.valid && !full;

    sfr_ctrl #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_write  (i_cfg.valid),
        .i_cfg_length (i_cfg.payload_length),
        .i_byte_valid (accept),
        .i_byte       (i_byte.rx_byte),
        .o_push       (push),
        .o_result     (ctrl_result)
    );

    sfr_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (ctrl_result),
        .o_full   (full),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (buf_result)
    );

    assign o_result.result_kind  = buf_result.result_kind;
    assign o_result.payload_byte = buf_result.payload_byte;
    assign o_result.frame_status = buf_result.frame_status;

endmodule

// ===== verif/sfr_frame_checker.sv =====
// Checker that predicts and compares the results of the framed serial receiver.
`timescale 1ns / 1ps
module sfr_frame_checker
    import sfr_pkg::*;
#(
    parameter int unsigned MAX_LEN = 4096
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sfr_cfg_if    i_cfg,
    sfr_byte_if   i_byte,
    sfr_result_if i_result,
    output int    o_mismatches,
    output int    o_pending,
    output logic  o_hunting,
    output int    o_payload_results,
    output int    o_good_frames,
    output int    o_footer_errors,
    output int    o_crc_errors
);

    typedef enum logic [1:0] {
        SEEK_HEADER,
        IN_PAYLOAD,
        IN_CRC,
        IN_FOOTER
    } t_rx_phase;

    t_rx_phase        rx_phase;
    logic [23:0]      hdr_window;
    logic [LEN_W-1:0] byte_idx;
    logic [LEN_W-1:0] len_reg;
    logic [15:0]      crc_acc;
    logic [15:0]      crc_rx;
    logic             footer_ok;
    t_result          expected_results[$];

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        r = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    task report_mismatch(input string what, input int got, input int want);
        o_mismatches++;
        if (o_mismatches <= 40) begin
            $display("checker: %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want, $time);
        end
    endtask

    task check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected",
                            {i_result.result_kind, i_result.payload_byte, i_result.frame_status}, 0);
            return;
        end
        want = expected_results.pop_front();
        if (i_result.result_kind !== want.result_kind) begin
            report_mismatch("result kind", i_result.result_kind, want.result_kind);
        end
        if (i_result.payload_byte !== want.payload_byte) begin
            report_mismatch("payload byte", i_result.payload_byte, want.payload_byte);
        end
        if (i_result.frame_status !== want.frame_status) begin
            report_mismatch("frame status", i_result.frame_status, want.frame_status);
        end
    endtask

    task take_byte(input logic [7:0] data);
        t_result          r;
        logic [LEN_W-1:0] lim;
        logic [7:0]       ftr_want;
        r = '0;
        case (rx_phase)
            SEEK_HEADER: begin
                if (hdr_window == {HDR_BYTE_0, HDR_BYTE_1, HDR_BYTE_2} && data == HDR_BYTE_3) begin
                    rx_phase   = IN_PAYLOAD;
                    byte_idx   = '0;
                    crc_acc    = CRC_INIT;
                    crc_rx     = '0;
                    footer_ok  = 1'b1;
                    hdr_window = '0;
                end else begin
                    hdr_window = {hdr_window[15:0], data};
                end
            end
            IN_PAYLOAD: begin
                crc_acc  = crc16_next(crc_acc, data);
                byte_idx = byte_idx + 1'b1;
                if (len_reg == '0) begin
                    lim = LEN_W'(1);
                end else if (len_reg > MAX_LEN) begin
                    lim = LEN_W'(MAX_LEN);
                end else begin
                    lim = len_reg;
                end
                if (byte_idx >= lim) begin
                    rx_phase = IN_CRC;
                    byte_idx = '0;
                end
                r.result_kind  = KIND_PAYLOAD;
                r.payload_byte = data;
                r.frame_status = STATUS_GOOD;
                expected_results.push_back(r);
                o_payload_results++;
            end
            IN_CRC: begin
                if (byte_idx == '0) begin
                    crc_rx   = {8'h00, data};
                    byte_idx = LEN_W'(1);
                end else begin
                    crc_rx[15:8] = data;
                    rx_phase     = IN_FOOTER;
                    byte_idx     = '0;
                end
            end
            default: begin
                case (byte_idx[1:0])
                    2'd0:    ftr_want = FTR_BYTE_0;
                    2'd1:    ftr_want = FTR_BYTE_1;
                    2'd2:    ftr_want = FTR_BYTE_2;
                    default: ftr_want = FTR_BYTE_3;
                endcase
                if (data != ftr_want) begin
                    footer_ok = 1'b0;
                end
                if (byte_idx[1:0] != 2'd3) begin
                    byte_idx = {{(LEN_W-2){1'b0}}, byte_idx[1:0]} + 1'b1;
                end else begin
                    r.result_kind  = KIND_STATUS;
                    r.payload_byte = 8'h00;
                    if (!footer_ok) begin
                        r.frame_status = STATUS_BAD_FOOTER;
                        o_footer_errors++;
                    end else if (crc_rx != crc_acc) begin
                        r.frame_status = STATUS_BAD_CRC;
                        o_crc_errors++;
                    end else begin
                        r.frame_status = STATUS_GOOD;
                        o_good_frames++;
                    end
                    expected_results.push_back(r);
                    rx_phase   = SEEK_HEADER;
                    hdr_window = '0;
                    byte_idx   = '0;
                    footer_ok  = 1'b1;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_phase          = SEEK_HEADER;
            hdr_window        = '0;
            byte_idx          = '0;
            len_reg           = LEN_RESET;
            crc_acc           = CRC_INIT;
            crc_rx            = '0;
            footer_ok         = 1'b1;
            o_mismatches      = 0;
            o_payload_results = 0;
            o_good_frames     = 0;
            o_footer_errors   = 0;
            o_crc_errors      = 0;
            expected_results.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                check_result();
            end
            if (i_byte.valid && i_byte.ready) begin
                take_byte(i_byte.rx_byte);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                len_reg = i_cfg.payload_length;
            end
        end
        o_pending = expected_results.size();
        o_hunting = (rx_phase == SEEK_HEADER);
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the framed serial receiver testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import sfr_pkg::*;

    localparam int unsigned MAX_LEN = 4096;
    localparam int RESET_CYCLES  = 7;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES  = 1600;
    localparam int LIMIT_CYCLES  = 3_000_000;

    typedef enum int {
        FILL_RANDOM,
        FILL_COUNT,
        FILL_MARKERS,
        FILL_EXTREMES,
        FILL_ONES,
        FILL_ZEROS
    } t_fill;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sfr_cfg_if    cfg_ch ();
    sfr_byte_if   byte_ch ();
    sfr_result_if res_ch ();

    int   mismatches;
    int   pending;
    logic hunting;
    int   payload_results;
    int   good_frames;
    int   footer_errors;
    int   crc_errors;

    int cycles        = 0;
    int bytes_sent    = 0;
    int settings_used = 0;
    int hold_req      = 0;
    int holds_served  = 0;
    int quiet_left    = 0;

    serial_frame_receiver_crc16_core #(
        .MAX_PAYLOAD_BYTES(MAX_LEN)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_byte  (byte_ch),
        .o_result(res_ch)
    );

    sfr_frame_checker #(
        .MAX_LEN(MAX_LEN)
    ) frame_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg            (cfg_ch),
        .i_byte           (byte_ch),
        .i_result         (res_ch),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_hunting        (hunting),
        .o_payload_results(payload_results),
        .o_good_frames    (good_frames),
        .o_footer_errors  (footer_errors),
        .o_crc_errors     (crc_errors)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("run stopped after %0d cycles, %0d results outstanding", cycles, pending);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        r = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] marker_byte();
        case ($urandom_range(0, 3))
            0:       return HDR_BYTE_0;
            1:       return HDR_BYTE_1;
            2:       return HDR_BYTE_2;
            default: return HDR_BYTE_3;
        endcase
    endfunction

    function automatic logic [7:0] pick_payload(input t_fill fill, input int k);
        case (fill)
            FILL_COUNT:    return 8'(k);
            FILL_MARKERS:  return marker_byte();
            FILL_EXTREMES: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            FILL_ONES:     return 8'hFF;
            FILL_ZEROS:    return 8'h00;
            default:       return 8'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet_left = $urandom_range(50, 200);
        end
        if (r < 70) begin
            return 0;
        end
        if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Entered and left at a falling edge; valid stays high on return so that
    // back-to-back requests need no toggling.
    task automatic push_byte(input logic [7:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.rx_byte = data;
        byte_ch.valid   = 1'b1;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_header();
        push_byte(HDR_BYTE_0);
        push_byte(HDR_BYTE_1);
        push_byte(HDR_BYTE_2);
        push_byte(HDR_BYTE_3);
    endtask

    task automatic send_frame(input int n, input bit crc_bad, input bit ftr_bad, input t_fill fill);
        logic [15:0] crc;
        logic [7:0]  data;
        logic [7:0]  ftr [4];
        int          k;
        crc = CRC_INIT;
        ftr = '{FTR_BYTE_0, FTR_BYTE_1, FTR_BYTE_2, FTR_BYTE_3};
        send_header();
        for (k = 0; k < n; k++) begin
            data = pick_payload(fill, k);
            crc  = crc_after(crc, data);
            push_byte(data);
        end
        if (crc_bad) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        if (ftr_bad) begin
            k      = $urandom_range(0, 3);
            ftr[k] = ftr[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        push_byte(crc[7:0]);
        push_byte(crc[15:8]);
        for (k = 0; k < 4; k++) begin
            push_byte(ftr[k]);
        end
    endtask

    task automatic send_noise(input int n);
        for (int k = 0; k < n; k++) begin
            push_byte(($urandom_range(0, 1) != 0) ? marker_byte() : 8'($urandom));
        end
    endtask

    task automatic send_truncated(input int n);
        int cut;
        cut = $urandom_range(0, n - 1);
        send_header();
        for (int k = 0; k < cut; k++) begin
            push_byte(8'($urandom));
        end
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        cfg_ch.payload_length = value;
        cfg_ch.valid          = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        settings_used++;
    endtask

    // Completes any frame still open, then lets every expected result drain.
    task automatic finish_phase();
        while (!hunting) push_byte(8'h00);
        byte_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        int r;
        int stall_left;
        int open_left;
        stall_left   = 0;
        open_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_req) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_served++;
            end else if (stall_left > 0) begin
                res_ch.ready = 1'b0;
                stall_left--;
            end else begin
                res_ch.ready = 1'b1;
                if (open_left > 0) begin
                    open_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 25) begin
                        stall_left = $urandom_range(1, 3);
                    end else if (r < 29) begin
                        stall_left = $urandom_range(8, 40);
                    end else if (r < 31) begin
                        open_left = $urandom_range(100, 300);
                    end
                end
            end
        end
    end

    initial begin
        int    start_count;
        int    len;
        int    kind;
        int    r;
        t_fill fill;
        byte_ch.valid         = 1'b0;
        byte_ch.rx_byte       = 8'h00;
        cfg_ch.valid          = 1'b0;
        cfg_ch.payload_length = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        hold_req++;
        send_frame(256, 1'b0, 1'b0, FILL_COUNT);
        finish_phase();

        write_length(LEN_W'(1));
        push_byte(HDR_BYTE_0);
        send_frame(1, 1'b0, 1'b0, FILL_ONES);
        push_byte(HDR_BYTE_1);
        push_byte(HDR_BYTE_2);
        push_byte(HDR_BYTE_3);
        push_byte(8'h00);
        send_frame(1, 1'b1, 1'b0, FILL_ZEROS);
        finish_phase();

        write_length('0);
        send_frame(1, 1'b1, 1'b1, FILL_RANDOM);
        finish_phase();

        start_count = bytes_sent;
        hold_req++;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = $urandom_range(1, 8);
            end else if (r < 95) begin
                len = $urandom_range(9, 64);
            end else begin
                len = $urandom_range(65, 300);
            end
            write_length(LEN_W'(len));
            if ($urandom_range(0, 19) == 0) begin
                hold_req++;
            end
            repeat ($urandom_range(2, 8)) begin
                kind = $urandom_range(0, 99);
                fill = t_fill'($urandom_range(0, 3));
                if (kind < 64) begin
                    send_frame(len, 1'b0, 1'b0, fill);
                end else if (kind < 70) begin
                    send_frame(len, 1'b1, 1'b0, fill);
                end else if (kind < 75) begin
                    send_frame(len, 1'b0, 1'b1, fill);
                end else if (kind < 78) begin
                    send_frame(len, 1'b1, 1'b1, fill);
                end else if (kind < 90) begin
                    send_noise($urandom_range(1, 12));
                end else begin
                    send_truncated(len);
                end
            end
            finish_phase();
        end

        $display("covered %0d bytes over %0d length settings, %0d payload bytes passed on",
                 bytes_sent, settings_used, payload_results);
        $display("frames: %0d good, %0d bad footer, %0d CRC mismatch; lengths 0 to 300 used",
                 good_frames, footer_errors, crc_errors);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
